### rtl/conv3_pkg.sv
// Shared types and constants for the 3x3 replicated-border convolution block.
// Used by every module under rtl; depends on nothing else.
package conv3_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 4096;
	localparam int KERNEL_SIZE = 3;
	localparam int PIXEL_BITS  = 8;

	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int WIDTH_W  = COL_W + 1;
	localparam int HEIGHT_W = ROW_W + 1;

	localparam int COEF_W = 16;
	localparam int KROW_W = KERNEL_SIZE * COEF_W;
	localparam int PROD_W = PIXEL_BITS + 1 + COEF_W;
	localparam int RSUM_W = PROD_W + 2;
	localparam int CONV_W = 28;

	localparam int OUT_FIELDS_W = ROW_W + COL_W + CONV_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH   = 3'd0,
		CFG_IMAGE_HEIGHT  = 3'd1,
		CFG_KERNEL_TOP    = 3'd2,
		CFG_KERNEL_MIDDLE = 3'd3,
		CFG_KERNEL_BOTTOM = 3'd4
	} cfg_index_t;

	// Bit positions of the result kinds one pixel can cause, in emission order.
	localparam int RES_ABOVE_INNER = 0;
	localparam int RES_ABOVE_EDGE  = 1;
	localparam int RES_LAST_INNER  = 2;
	localparam int RES_LAST_EDGE   = 3;
	localparam int RES_KINDS       = 4;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef pixel_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] window_t;
	typedef logic [KERNEL_SIZE-1:0][KROW_W-1:0] kernel_t;

	typedef struct packed {
		pixel_t older;
		pixel_t newer;
	} line_word_t;

	typedef struct packed {
		window_t                win;
		logic [ROW_W-1:0]       row;
		logic [COL_W-1:0]       col;
		logic [RES_KINDS-1:0]   kinds;
	} job_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} res_meta_t;

endpackage

### rtl/conv3_line_mem.sv
// Two-row line memory: one entry per column holds the pixels of the two previous rows.
// Synchronous read with a registered output; depends on conv3_pkg.
module conv3_line_mem import conv3_pkg::*; (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	output line_word_t       rd_data,
	input  logic             wr_en,
	input  logic [COL_W-1:0] wr_addr,
	input  line_word_t       wr_data
);

	line_word_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/conv3_front.sv
// Input side: position counters, line memory read-modify-write with forwarding,
// the 3x3 window and the list of results each pixel causes. Depends on conv3_pkg.
module conv3_front import conv3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  pixel_t                pix,
	input  logic [WIDTH_W-1:0]    image_width,
	input  logic [HEIGHT_W-1:0]   image_height,
	input  logic [FIFO_CNT_W-1:0] fifo_count,
	output logic                  job_valid,
	output job_t                  job
);

	logic             accept;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             last_col;
	logic             last_row;

	logic             s1_valid_q;
	pixel_t           s1_pix;
	logic [ROW_W-1:0] s1_row;
	logic [COL_W-1:0] s1_col;
	logic             s1_last_col;
	logic             s1_last_row;
	logic             s1_fwd_hit;
	line_word_t       s1_fwd_word;

	line_word_t rd_word;
	line_word_t prev_word;
	line_word_t wr_word;
	pixel_t     top_px;
	pixel_t     mid_px;
	pixel_t     [KERNEL_SIZE-1:0] vals;
	window_t    win_q;
	window_t    win_next;
	logic [RES_KINDS-1:0] kinds;

	assign pix_ready = (fifo_count + FIFO_CNT_W'(s1_valid_q)) < FIFO_CNT_W'(FIFO_DEPTH);
	assign accept    = pix_valid && pix_ready;
	assign last_col  = ({1'b0, col_q} + WIDTH_W'(1)) >= image_width;
	assign last_row  = ({1'b0, row_q} + HEIGHT_W'(1)) >= image_height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// The item in stage 1 writes its entry at the same edge the next item reads;
	// a match on the column forwards that write.
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_pix      <= pix;
			s1_row      <= row_q;
			s1_col      <= col_q;
			s1_last_col <= last_col;
			s1_last_row <= last_row;
			s1_fwd_hit  <= s1_valid_q && (s1_col == col_q);
			s1_fwd_word <= wr_word;
		end
	end

	conv3_line_mem u_line_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_word),
		.wr_en   (s1_valid_q),
		.wr_addr (s1_col),
		.wr_data (wr_word)
	);

	always_comb begin
		prev_word     = s1_fwd_hit ? s1_fwd_word : rd_word;
		mid_px        = (s1_row == '0) ? s1_pix : prev_word.newer;
		top_px        = (s1_row <= ROW_W'(1)) ? mid_px : prev_word.older;
		wr_word.older = mid_px;
		wr_word.newer = s1_pix;
		vals[0]       = top_px;
		vals[1]       = mid_px;
		vals[2]       = s1_pix;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			if (s1_col == '0) begin
				for (int j = 0; j < KERNEL_SIZE; j++) begin
					win_next[i][j] = vals[i];
				end
			end else begin
				win_next[i][0] = win_q[i][1];
				win_next[i][1] = win_q[i][2];
				win_next[i][2] = vals[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_valid_q) begin
			win_q <= win_next;
		end
	end

	always_comb begin
		kinds                  = '0;
		kinds[RES_ABOVE_INNER] = (s1_row != '0) && (s1_col != '0);
		kinds[RES_ABOVE_EDGE]  = (s1_row != '0) && s1_last_col;
		kinds[RES_LAST_INNER]  = s1_last_row && (s1_col != '0);
		kinds[RES_LAST_EDGE]   = s1_last_row && s1_last_col;
	end

	assign job_valid = s1_valid_q && (kinds != '0);
	assign job.win   = win_next;
	assign job.row   = s1_row;
	assign job.col   = s1_col;
	assign job.kinds = kinds;

endmodule

### rtl/conv3_job_fifo.sv
// Small queue of window snapshots waiting for the multiply-accumulate pipeline.
// Flip-flop storage read at the head pointer; depends on conv3_pkg.
module conv3_job_fifo import conv3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  job_t                  push_job,
	input  logic                  pop,
	output logic                  head_valid,
	output job_t                  head_job,
	output logic [FIFO_CNT_W-1:0] count
);

	job_t                  mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
		end
	end

	assign head_valid = count_q != '0;
	assign head_job   = mem[rd_ptr_q];
	assign count      = count_q;

endmodule

### rtl/conv3_mac.sv
// Result sequencer and MAC pipeline: one result per cycle, unless stalled, from the
// queued windows, nine products, row sums, total and output register. Depends on conv3_pkg.
module conv3_mac import conv3_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kernel_t                  kernel,
	input  logic                     head_valid,
	input  job_t                     head_job,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output res_meta_t                out_meta,
	output logic signed [CONV_W-1:0] out_value
);

	function automatic logic [1:0] tap(input logic shift, input int i);
		if (shift) begin
			return (i == 0) ? 2'd1 : 2'd2;
		end
		return 2'(i);
	endfunction

	logic                 en;
	logic                 issue;
	logic [RES_KINDS-1:0] issued_q;
	logic [RES_KINDS-1:0] pending;
	logic [RES_KINDS-1:0] sel;
	logic [RES_KINDS-1:0] remaining;
	logic                 row_shift;
	logic                 col_shift;
	res_meta_t            meta_c;

	logic signed [PROD_W-1:0] prod_c [KERNEL_SIZE][KERNEL_SIZE];

	logic                     m1_valid_q;
	logic signed [PROD_W-1:0] m1_prod [KERNEL_SIZE][KERNEL_SIZE];
	res_meta_t                m1_meta;

	logic                     m2_valid_q;
	logic signed [RSUM_W-1:0] m2_sum [KERNEL_SIZE];
	res_meta_t                m2_meta;

	logic                     out_valid_q;
	res_meta_t                out_meta_q;
	logic signed [CONV_W-1:0] out_value_q;
	logic signed [CONV_W-1:0] total_c;

	assign en        = !out_valid_q || out_ready;
	assign pending   = head_job.kinds & ~issued_q;
	assign sel       = pending & (~pending + RES_KINDS'(1));
	assign remaining = pending & ~sel;
	assign issue     = en && head_valid;
	assign pop       = issue && (remaining == '0);
	assign row_shift = sel[RES_LAST_INNER] | sel[RES_LAST_EDGE];
	assign col_shift = sel[RES_ABOVE_EDGE] | sel[RES_LAST_EDGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_q <= '0;
		end else if (issue) begin
			issued_q <= pop ? '0 : (issued_q | sel);
		end
	end

	always_comb begin
		meta_c.row  = row_shift ? head_job.row : head_job.row - ROW_W'(1);
		meta_c.col  = col_shift ? head_job.col : head_job.col - COL_W'(1);
		meta_c.last = sel[RES_LAST_EDGE];
	end

	always_comb begin
		pixel_t                   px;
		logic        [COEF_W-1:0] cf;
		logic signed [PROD_W-1:0] px_ext;
		logic signed [PROD_W-1:0] cf_ext;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			for (int j = 0; j < KERNEL_SIZE; j++) begin
				px           = head_job.win[tap(row_shift, i)][tap(col_shift, j)];
				cf           = kernel[i][COEF_W*j +: COEF_W];
				px_ext       = {{(PROD_W-PIXEL_BITS){1'b0}}, px};
				cf_ext       = {{(PROD_W-COEF_W){cf[COEF_W-1]}}, cf};
				prod_c[i][j] = px_ext * cf_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_valid_q  <= 1'b0;
			m2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			m1_valid_q  <= head_valid;
			m2_valid_q  <= m1_valid_q;
			out_valid_q <= m2_valid_q;
		end
	end

	always_comb begin
		total_c = '0;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			total_c = total_c + {{(CONV_W-RSUM_W){m2_sum[i][RSUM_W-1]}}, m2_sum[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_prod     <= prod_c;
			m1_meta     <= meta_c;
			m2_meta     <= m1_meta;
			out_meta_q  <= m2_meta;
			out_value_q <= total_c;
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				m2_sum[i] <= {{2{m1_prod[i][0][PROD_W-1]}}, m1_prod[i][0]}
					+ {{2{m1_prod[i][1][PROD_W-1]}}, m1_prod[i][1]}
					+ {{2{m1_prod[i][2][PROD_W-1]}}, m1_prod[i][2]};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_meta  = out_meta_q;
	assign out_value = out_value_q;

endmodule

### rtl/conv2d_3x3_replicate_border.sv
// Top level of the streaming 3x3 convolution with replicated borders.
// Holds the configuration registers and connects front end, queue and MAC pipeline.
// Depends on conv3_pkg, conv3_front, conv3_job_fifo and conv3_mac.
//
// Pixels enter in raster order on the s_axis channel, one per transfer. Results
// leave on the m_axis channel as row, column and signed sum; tlast marks the
// result for the last row and last column of the frame. The result for pixel
// (r-1, c-1) is produced when pixel (r, c) arrives; during the last row the
// results of that row are interleaved, so one pixel causes up to four results.
// The block takes one pixel per cycle while the queue has room, and results
// average one per pixel; the single output stage delivers one result per cycle
// while the receiver is ready, so the last row and row ends run at the rate the
// output allows. An eight-entry window queue sits between the line memory side
// and the MAC pipeline; its fill sets s_axis_tready. When the receiver stalls,
// the MAC pipeline holds and the queue absorbs input until it fills. Reset
// clears the position counters, the window and the queue, and sets width 1024,
// height 4096 and an all-zero kernel. The cfg channel is always ready and should
// be written only while no result is outstanding.
module conv2d_3x3_replicate_border import conv3_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [PIXEL_BITS-1:0]  s_axis_tdata,  // [7:0] pixel
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [11:0] out_row, [21:12] out_col,
	                                              // [49:22] conv_value, rest zero
	output logic                   m_axis_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [KROW_W-1:0]      cfg_data
);

	logic [WIDTH_W-1:0]    width_q;
	logic [HEIGHT_W-1:0]   height_q;
	kernel_t               kernel_q;
	logic [WIDTH_W-1:0]    width_in;
	logic [HEIGHT_W-1:0]   height_in;

	logic                  job_valid;
	job_t                  job;
	logic                  head_valid;
	job_t                  head_job;
	logic                  pop;
	logic [FIFO_CNT_W-1:0] fifo_count;
	res_meta_t             out_meta;
	logic signed [CONV_W-1:0] out_value;

	assign cfg_ready = 1'b1;
	assign width_in  = cfg_data[WIDTH_W-1:0];
	assign height_in = cfg_data[HEIGHT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(MAX_WIDTH);
			height_q <= HEIGHT_W'(MAX_HEIGHT);
			kernel_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH: begin
					if (width_in == '0) begin
						width_q <= WIDTH_W'(1);
					end else if (width_in > WIDTH_W'(MAX_WIDTH)) begin
						width_q <= WIDTH_W'(MAX_WIDTH);
					end else begin
						width_q <= width_in;
					end
				end
				CFG_IMAGE_HEIGHT: begin
					if (height_in == '0) begin
						height_q <= HEIGHT_W'(1);
					end else if (height_in > HEIGHT_W'(MAX_HEIGHT)) begin
						height_q <= HEIGHT_W'(MAX_HEIGHT);
					end else begin
						height_q <= height_in;
					end
				end
				CFG_KERNEL_TOP:    kernel_q[0] <= cfg_data;
				CFG_KERNEL_MIDDLE: kernel_q[1] <= cfg_data;
				CFG_KERNEL_BOTTOM: kernel_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	conv3_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (s_axis_tvalid),
		.pix_ready    (s_axis_tready),
		.pix          (s_axis_tdata),
		.image_width  (width_q),
		.image_height (height_q),
		.fifo_count   (fifo_count),
		.job_valid    (job_valid),
		.job          (job)
	);

	conv3_job_fifo u_job_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_valid),
		.push_job   (job),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job),
		.count      (fifo_count)
	);

	conv3_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.kernel     (kernel_q),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_meta   (out_meta),
		.out_value  (out_value)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_value,
		out_meta.col, out_meta.row};
	assign m_axis_tlast = out_meta.last;

endmodule

### rtl/conv3_checker.sv
// Port-level checks for conv2d_3x3_replicate_border, attached by the bind below.
// Depends on conv3_pkg and the top level's port list.
module conv3_checker import conv3_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [11:0] out_row, [21:12] out_col,
	                                             // [49:22] conv_value, rest zero
	input logic                   m_axis_tlast
);

	logic out_xfer;
	logic frame_start_q;

	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// Set after reset and after the transfer that closes a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= 1'b1;
		end else if (out_xfer) begin
			frame_start_q <= m_axis_tlast;
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("Result valid dropped while stalled.");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("Result payload changed while stalled.");

	a_frame_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && frame_start_q |-> m_axis_tdata[ROW_W-1:0] == '0
			&& m_axis_tdata[ROW_W+COL_W-1:ROW_W] == '0)
		else $error("First result of a frame is not at row 0, column 0.");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0)
		else $error("Result padding bits are not zero.");

endmodule

bind conv2d_3x3_replicate_border conv3_checker u_checker (.*);
